// ----- src/bd2a_pkg.sv -----
// ----------------------------------------------------------------------------
// bd2a_pkg
// Shared constants and elaboration helpers for the binary to decimal ASCII
// converter.
// ----------------------------------------------------------------------------
package bd2a_pkg;

   localparam int IN_BITS            = 32;
   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int BCD_BITS           = 4;
   localparam int STEP_BITS          = 4;
   localparam int CHAR_BITS          = 6;
   localparam int RSP_TDATA_W        = 8;
   localparam int REQ_TDATA_W        = 32;
   localparam longint unsigned RADIX = 10;

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'h30;

   // Decimal digit count of the largest value that fits in bits.
   function automatic int num_digits(input int bits);
      longint unsigned v;
      int              n;
      v = (bits >= 64) ? ~64'd0 : ((64'd1 << bits) - 64'd1);
      n = 0;
      do begin
         n++;
         v = v / RADIX;
      end while (v != 0);
      return n;
   endfunction

endpackage

// ----- src/bd2a_dabble_stage.sv -----
// ----------------------------------------------------------------------------
// bd2a_dabble_stage
// One registered slice of the shift-and-add-3 converter: runs STEPS
// double-dabble steps and holds the result under a valid/ready handshake.
// ----------------------------------------------------------------------------
module bd2a_dabble_stage #(
   parameter int BIN_BITS   = 32,
   parameter int NUM_DIGITS = 10,
   parameter int STEPS      = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [NUM_DIGITS*bd2a_pkg::BCD_BITS-1:0] in_bcd,
   input  logic [BIN_BITS-1:0]                      in_bin,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [NUM_DIGITS*bd2a_pkg::BCD_BITS-1:0] out_bcd,
   output logic [BIN_BITS-1:0]                      out_bin
);

   localparam int BCD_W = NUM_DIGITS * bd2a_pkg::BCD_BITS;

   logic             valid_ff;
   logic             valid_in;
   logic [BCD_W-1:0] bcd_ff;
   logic [BCD_W-1:0] bcd_in;
   logic [BIN_BITS-1:0] bin_ff;
   logic [BIN_BITS-1:0] bin_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_bcd   = bcd_ff;
   assign out_bin   = bin_ff;

   // Adjust each digit, then shift the next binary bit into the BCD word.
   always_comb begin
      bcd_in = in_bcd;
      bin_in = in_bin;
      for (int s = 0; s < STEPS; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_in[d*bd2a_pkg::BCD_BITS +: bd2a_pkg::BCD_BITS] >= 4'd5) begin
               bcd_in[d*bd2a_pkg::BCD_BITS +: bd2a_pkg::BCD_BITS] =
                  bcd_in[d*bd2a_pkg::BCD_BITS +: bd2a_pkg::BCD_BITS] + 4'd3;
            end
         end
         bcd_in = {bcd_in[BCD_W-2:0], bin_in[BIN_BITS-1]};
         bin_in = {bin_in[BIN_BITS-2:0], 1'b0};
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         bcd_ff <= bcd_in;
         bin_ff <= bin_in;
      end
   end

   // Hold the slice while the next one stalls.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_bcd) && $stable(out_bin))
      else $error("dabble stage changed while stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && !in_valid |=> !out_valid)
      else $error("dabble stage kept a transaction after hand-off");

endmodule

// ----- src/bd2a_serializer.sv -----
// ----------------------------------------------------------------------------
// bd2a_serializer
// Takes a finished BCD word, skips leading zeros and sends one ASCII digit
// per transaction, most significant first, marking the last.
// ----------------------------------------------------------------------------
module bd2a_serializer #(
   parameter int NUM_DIGITS = 10
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [NUM_DIGITS*bd2a_pkg::BCD_BITS-1:0] in_bcd,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [bd2a_pkg::CHAR_BITS-1:0]           out_char,
   output logic                                     out_last
);

   localparam int IDX_W = $clog2(NUM_DIGITS);

   logic                          busy_ff;
   logic                          busy_in;
   logic [IDX_W-1:0]              idx_ff;
   logic [IDX_W-1:0]              idx_in;
   logic [bd2a_pkg::BCD_BITS-1:0] digits_ff [NUM_DIGITS];
   logic [IDX_W-1:0]              first_idx;
   logic                          load;
   logic [bd2a_pkg::BCD_BITS-1:0] cur_digit;

   // Highest nonzero digit; zero value leaves the units digit.
   always_comb begin
      first_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (in_bcd[d*bd2a_pkg::BCD_BITS +: bd2a_pkg::BCD_BITS] != '0) begin
            first_idx = IDX_W'(d);
         end
      end
   end

   assign out_last  = (idx_ff == '0);
   assign in_ready  = !busy_ff || (out_ready && out_last);
   assign load      = in_valid && in_ready;
   assign out_valid = busy_ff;
   assign cur_digit = digits_ff[idx_ff];
   assign out_char  = bd2a_pkg::ASCII_ZERO
                      + {{(bd2a_pkg::CHAR_BITS-bd2a_pkg::BCD_BITS){1'b0}}, cur_digit};

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = first_idx;
      end else if (busy_ff && out_ready) begin
         if (out_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      if (load) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            digits_ff[d] <= in_bcd[d*bd2a_pkg::BCD_BITS +: bd2a_pkg::BCD_BITS];
         end
      end
   end

   // A run never opens with a zero unless it is the lone digit.
   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      load |=> (cur_digit != '0) || out_last)
      else $error("run opened with a leading zero");

   a_step_down: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && !out_last |=> out_valid && (idx_ff == $past(idx_ff) - 1'b1))
      else $error("digit position did not advance");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && out_last && !in_valid |=> !out_valid)
      else $error("output stayed valid after the last digit");

   a_no_load_mid_run: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !out_last |-> !load)
      else $error("new value taken in the middle of a run");

endmodule

// ----- src/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to decimal ASCII text converter, pipelined double dabble
// followed by a digit serializer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one unsigned value per transaction; only the low VALUE_BITS
//   bits are converted. rsp_* returns the decimal text, one ASCII character
//   per transaction, most significant first, no leading zeros; zero gives a
//   single '0'. rsp_tlast marks the units digit that closes each run.
//   Conversion runs through ceil(min(VALUE_BITS,32)/4) pipeline stages, at most
//   four shift-add-3 steps each (8 stages for 32 bits); the value passes the
//   stage registers and then the serializer register before rsp_tvalid rises.
//   The serializer then sends one digit per cycle while rsp_tready is high
//   (1 to 10 digits for 32 bits) and takes the next value with the last
//   digit. Values queue in the pipeline while a run is being sent.
//   Reset clears every valid bit; nothing else is kept between values.
//   When the receiver holds rsp_tready low the current digit is held, the
//   pipeline fills and then req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = bd2a_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bd2a_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bd2a_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [5:0] digit_char, [7:6] zero
   output logic                             rsp_tlast
);

   localparam int EFF_BITS   = (VALUE_BITS < bd2a_pkg::IN_BITS) ? VALUE_BITS
                                                                 : bd2a_pkg::IN_BITS;
   localparam int NUM_DIGITS = bd2a_pkg::num_digits(EFF_BITS);
   localparam int BCD_W      = NUM_DIGITS * bd2a_pkg::BCD_BITS;
   localparam int NUM_STAGES = (EFF_BITS + bd2a_pkg::STEP_BITS - 1) / bd2a_pkg::STEP_BITS;

   logic [NUM_STAGES:0] vld;
   logic [NUM_STAGES:0] rdy;
   logic [BCD_W-1:0]    bcd_chain [NUM_STAGES+1];
   logic [EFF_BITS-1:0] bin_chain [NUM_STAGES+1];
   logic [bd2a_pkg::CHAR_BITS-1:0] digit_char;

   assign vld[0]       = req_tvalid;
   assign req_tready   = rdy[0];
   assign bcd_chain[0] = '0;
   assign bin_chain[0] = req_tdata[EFF_BITS-1:0];

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      localparam int LEFT  = EFF_BITS - g * bd2a_pkg::STEP_BITS;
      localparam int STEPS = (LEFT < bd2a_pkg::STEP_BITS) ? LEFT : bd2a_pkg::STEP_BITS;

      bd2a_dabble_stage #(
         .BIN_BITS   (EFF_BITS),
         .NUM_DIGITS (NUM_DIGITS),
         .STEPS      (STEPS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[g]),
         .in_ready  (rdy[g]),
         .in_bcd    (bcd_chain[g]),
         .in_bin    (bin_chain[g]),
         .out_valid (vld[g+1]),
         .out_ready (rdy[g+1]),
         .out_bcd   (bcd_chain[g+1]),
         .out_bin   (bin_chain[g+1])
      );
   end

   bd2a_serializer #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld[NUM_STAGES]),
      .in_ready  (rdy[NUM_STAGES]),
      .in_bcd    (bcd_chain[NUM_STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (digit_char),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(bd2a_pkg::RSP_TDATA_W-bd2a_pkg::CHAR_BITS){1'b0}}, digit_char};

endmodule
